### hw/rtl/i64dec_pkg.sv
// ----------------------------------------------------------------------------
// i64dec_pkg: shared definitions for the decimal text converter
// Widths, character codes and the control group of the digit cells.
// ----------------------------------------------------------------------------
package i64dec_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 19;
    localparam int DIGIT_W     = 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    localparam logic [BIT_CNT_W-1:0]   LAST_BIT   = BIT_CNT_W'(VALUE_WIDTH - 1);
    localparam logic [DIGIT_CNT_W-1:0] ALL_DIGITS = DIGIT_CNT_W'(MAX_DIGITS);

    typedef struct packed {
        logic clear;
        logic dabble;
        logic move;
    } cell_ctrl_t;

endpackage

### hw/rtl/i64dec_cell.sv
// ----------------------------------------------------------------------------
// i64dec_cell: one decimal digit cell
// Clears, takes one binary bit with the add-three correction, or takes the
// digit of its lower neighbour to move the text up the row.
// ----------------------------------------------------------------------------
module i64dec_cell (
    input  logic                                clk,
    input  i64dec_pkg::cell_ctrl_t              ctrl,
    input  logic                                bit_in,
    input  logic [i64dec_pkg::DIGIT_W-1:0]      digit_in,
    output logic                                bit_out,
    output logic [i64dec_pkg::DIGIT_W-1:0]      digit
);

    logic [i64dec_pkg::DIGIT_W-1:0] digit_reg;
    logic [i64dec_pkg::DIGIT_W-1:0] digit_next;
    logic [i64dec_pkg::DIGIT_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    end

    assign bit_out = adj[i64dec_pkg::DIGIT_W-1];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[i64dec_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.move)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

### hw/rtl/signed_int64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int64_to_decimal_ascii: 64-bit signed integer to decimal ASCII text
//
// Input channel: value with in_valid / in_stall; a transfer happens when
// in_valid is high and in_stall low. in_stall is low only while idle.
// Output channel: char_code and last_char with out_valid / out_stall; one
// character per transfer, most significant first, a leading '-' for negative
// values, no leading zeros, last_char high on the final character.
// The magnitude runs through a row of 19 digit cells one bit a cycle,
// leading zero digits are moved out one a cycle, then one character
// leaves per cycle while the output is not stalled.
// A stalled output holds its character and stalls the row; the next input
// is taken while the final character still waits in the output register.
// Reset clears the control state and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module signed_int64_to_decimal_ascii (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic signed [i64dec_pkg::VALUE_WIDTH-1:0]   value,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic [7:0]                                  char_code,
    output logic                                        last_char
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int ND = i64dec_pkg::MAX_DIGITS;
    localparam int DW = i64dec_pkg::DIGIT_W;
    localparam int VW = i64dec_pkg::VALUE_WIDTH;

    logic [2:0]                             state_reg, state_next;
    logic [VW-1:0]                          mag_reg, mag_next;
    logic                                   neg_reg, neg_next;
    logic [i64dec_pkg::BIT_CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [i64dec_pkg::DIGIT_CNT_W-1:0]     left_reg, left_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [7:0]                             char_reg, char_next;
    logic                                   last_reg, last_next;

    i64dec_pkg::cell_ctrl_t                 ctrl;
    logic [DW-1:0]                          digit_w [ND];
    logic [ND-2:0]                          carry_w;
    logic [DW-1:0]                          top_digit;
    logic                                   out_free;
    logic                                   accept;
    logic [VW-1:0]                          raw;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign top_digit = digit_w[ND-1];
    assign raw       = $unsigned(value);

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    genvar gi;
    generate
        for (gi = 0; gi < ND; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_low
                i64dec_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (mag_reg[VW-1]),
                    .digit_in ({DW{1'b0}}),
                    .bit_out  (carry_w[0]),
                    .digit    (digit_w[0])
                );
            end
            else if (gi == ND - 1)
            begin : g_top
                i64dec_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (carry_w[gi-1]),
                    .digit_in (digit_w[gi-1]),
                    .bit_out  (),
                    .digit    (digit_w[gi])
                );
            end
            else
            begin : g_mid
                i64dec_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (carry_w[gi-1]),
                    .digit_in (digit_w[gi-1]),
                    .bit_out  (carry_w[gi]),
                    .digit    (digit_w[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        left_next      = left_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next     = raw[VW-1];
                    mag_next     = raw[VW-1] ? (~raw + 1'b1) : raw;
                    bit_cnt_next = '0;
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.dabble  = 1'b1;
                mag_next     = {mag_reg[VW-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == i64dec_pkg::LAST_BIT)
                begin
                    left_next  = i64dec_pkg::ALL_DIGITS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == '0) && (left_reg > 1))
                begin
                    ctrl.move = 1'b1;
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    char_next      = i64dec_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    char_next      = i64dec_pkg::CHAR_ZERO + {4'd0, top_digit};
                    last_next      = (left_reg == 1);
                    out_valid_next = 1'b1;
                    ctrl.move      = 1'b1;
                    left_next      = left_reg - 1'b1;
                    if (left_reg == 1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            left_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            left_reg      <= left_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: signed 64-bit integer to decimal ASCII converter
// A directed table of edge values, then random values of every length and
// sign. The sender transfers in bursts and the receiver stalls on changing
// patterns. Each character is checked against a local decimal predictor, or
// against typed-in text where the row gives it.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VALUE_WIDTH  = i64dec_pkg::VALUE_WIDTH;
    localparam int MAX_DIGITS   = i64dec_pkg::MAX_DIGITS;
    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_ITEMS = 138;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    typedef struct {
        logic [VALUE_WIDTH-1:0] number;
        string                  text;
    } stim_row_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef enum int {
        PICK_FULL,
        PICK_SHIFTED,
        PICK_DECADE_EDGE,
        PICK_SMALL
    } value_kind_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_stall;
    logic signed [VALUE_WIDTH-1:0]       value     = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [7:0]                          char_code;
    logic                                last_char;

    text_char_t  char_q[$];
    string       text_q[$];
    stim_row_t   stim_table[$];
    string       row_text;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;

    signed_int64_to_decimal_ascii u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    initial
    begin
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic void predict_decimal(input logic [VALUE_WIDTH-1:0] number);
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digits[MAX_DIGITS];
        int                     count;
        text_char_t             entry;
        mag   = number[VALUE_WIDTH-1] ? (~number + 1'b1) : number;
        count = 0;
        do
        begin
            digits[count] = 4'(mag % 10);
            mag           = mag / 10;
            count++;
        end
        while (mag != 0 && count < MAX_DIGITS);
        if (number[VALUE_WIDTH-1])
        begin
            entry = '{code: i64dec_pkg::CHAR_MINUS, last: 1'b0};
            char_q.push_back(entry);
        end
        for (int k = count; k > 0; k--)
        begin
            entry = '{code: i64dec_pkg::CHAR_ZERO + 8'(digits[k-1]), last: (k == 1)};
            char_q.push_back(entry);
        end
    endfunction

    function automatic void expect_typed(input string text);
        text_char_t entry;
        for (int i = 0; i < text.len(); i++)
        begin
            entry = '{code: 8'(text[i]), last: (i == text.len() - 1)};
            char_q.push_back(entry);
        end
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] power_of_ten(input int exponent);
        logic [VALUE_WIDTH-1:0] p;
        p = 1;
        for (int i = 0; i < exponent; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] v;
        value_kind_t            kind;
        kind = value_kind_t'($urandom_range(0, 3));
        case (kind)
            PICK_FULL:
                v = {$urandom, $urandom};
            PICK_SHIFTED:
                v = {$urandom, $urandom} >> $urandom_range(0, VALUE_WIDTH - 1);
            PICK_DECADE_EDGE:
                v = power_of_ten($urandom_range(0, MAX_DIGITS - 1))
                    + VALUE_WIDTH'($urandom_range(0, 2)) - 1'b1;
            default:
                v = VALUE_WIDTH'($urandom_range(0, 1000));
        endcase
        if (kind != PICK_FULL && $urandom_range(0, 1) == 1)
        begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    task automatic send_number(input logic [VALUE_WIDTH-1:0] number, input string text);
        int gap;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100)
                                              : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        text_q.push_back(text);
        value    <= number;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // transfer monitor: expectations first, then the character check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                row_text = text_q.pop_front();
                if (row_text.len() == 0)
                    predict_decimal(value);
                else
                    expect_typed(row_text);
            end
            if (out_valid && !out_stall)
            begin
                if (char_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character %0d", char_code));
                end
                else
                begin
                    if (char_code !== char_q[0].code)
                        report_mismatch($sformatf("char_code %0d, wanted %0d",
                                                  char_code, char_q[0].code));
                    if (last_char !== char_q[0].last)
                        report_mismatch($sformatf("last_char %0b, wanted %0b",
                                                  last_char, char_q[0].last));
                    void'(char_q.pop_front());
                end
            end
        end
    end

    initial
    begin : receiver
        stall_mode_t mode;
        int          span;
        int          phase;
        phase = 0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                phase++;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ((phase % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : sender
        stim_table.push_back('{64'sd0, "0"});
        stim_table.push_back('{64'sd1, "1"});
        stim_table.push_back('{-64'sd1, "-1"});
        stim_table.push_back('{64'sd9, "9"});
        stim_table.push_back('{64'sd10, "10"});
        stim_table.push_back('{-64'sd10, "-10"});
        stim_table.push_back('{64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"});
        stim_table.push_back('{64'h8000_0000_0000_0000, "-9223372036854775808"});
        stim_table.push_back('{64'h8000_0000_0000_0001, "-9223372036854775807"});
        stim_table.push_back('{64'sd1000000000000000000, "1000000000000000000"});
        stim_table.push_back('{64'sd999999999999999999, "999999999999999999"});
        stim_table.push_back('{-64'sd1000000000000000000, "-1000000000000000000"});
        stim_table.push_back('{64'sd99, ""});
        stim_table.push_back('{64'sd100, ""});
        stim_table.push_back('{-64'sd99, ""});
        stim_table.push_back('{64'sd12345, ""});
        stim_table.push_back('{-64'sd987654321, ""});
        stim_table.push_back('{64'h5555_5555_5555_5555, ""});
        stim_table.push_back('{64'hAAAA_AAAA_AAAA_AAAA, ""});
        stim_table.push_back('{64'h0123_4567_89AB_CDEF, ""});
        stim_table.push_back('{64'hFEDC_BA98_7654_3210, ""});
        stim_table.push_back('{64'h0000_0001_0000_0000, ""});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            send_number(stim_table[i].number, stim_table[i].text);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_number(pick_value(), "");
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (char_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
hw/rtl/i64dec_pkg.sv
hw/rtl/i64dec_cell.sv
hw/rtl/signed_int64_to_decimal_ascii.sv
dv/testbench.sv
